/* src/crpf_pkg.sv */
package crpf_pkg;

    localparam int COORD_W    = 32;
    localparam int TIME_W     = 24;
    localparam int PARAM_W    = 16;
    localparam int SEG_W      = 4;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int COEF_W     = 38;
    localparam int MUL_B_W    = 25;
    localparam int FRAC_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WAYPOINT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_DURATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION_INVERSE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIMATE_ENABLE   = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [COUNT_W-1:0] RST_COUNT    = 5'd4;
    localparam logic [TIME_W-1:0]  RST_DURATION = 24'd65536;
    localparam logic [TIME_W-1:0]  RST_INVERSE  = 24'd65536;

    typedef struct packed {
        logic                      op;
        logic [SEG_W-1:0]          waypoint_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [TIME_W-1:0]         time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [SEG_W-1:0]          segment;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

endpackage

/* src/catmull_rom_path_follower_top.sv */
// Load: taken in the idle state, no result; disabled tick: taken in the idle state, no result.
// Tick: index reduction (repeated subtraction of the waypoint count), fetch of 4 waypoints,
// 9 Horner steps (ST_MUL, then ST_ADD) on the shared multiplier, then emit; timer and parameter
// update (ST_TSUM, ST_TUPD, ST_PMUL, ST_PSET) follow, and only then is the next transfer taken;
// emit holds while the previous result still waits. Synchronous active-low reset restores the
// register defaults and clears timer, segment and parameter; the waypoint table is kept.
module catmull_rom_path_follower_top #(
    parameter int MAX_WAYPOINTS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  crpf_pkg::t_in_item                     i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output crpf_pkg::t_out_item                    o_out_data,
    input  logic                                   i_cfg_we,
    input  logic [crpf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [crpf_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = crpf_pkg::COUNT_W;
    localparam int HW = crpf_pkg::COEF_W;
    localparam int BW = crpf_pkg::MUL_B_W;
    localparam int PW = HW + BW;
    localparam int TW = crpf_pkg::TIME_W;
    localparam int FW = crpf_pkg::FRAC_W;
    localparam int XW = crpf_pkg::COORD_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_REDUCE = 4'd1;
    localparam logic [3:0] ST_FETCH  = 4'd2;
    localparam logic [3:0] ST_MUL    = 4'd3;
    localparam logic [3:0] ST_ADD    = 4'd4;
    localparam logic [3:0] ST_EMIT   = 4'd5;
    localparam logic [3:0] ST_TSUM   = 4'd6;
    localparam logic [3:0] ST_TUPD   = 4'd7;
    localparam logic [3:0] ST_PMUL   = 4'd8;
    localparam logic [3:0] ST_PSET   = 4'd9;

    logic [3:0]                       r_state, n_state;
    logic [CW-1:0]                    r_cfg_count;
    logic [TW-1:0]                    r_cfg_dur;
    logic [TW-1:0]                    r_cfg_inv;
    logic                             r_cfg_en;
    logic [crpf_pkg::SEG_W-1:0]       r_seg_idx, n_seg_idx;
    logic [TW-1:0]                    r_seg_time, n_seg_time;
    logic [FW-1:0]                    r_seg_param, n_seg_param;
    logic [CW-1:0]                    r_i0, n_i0;
    logic [CW-1:0]                    r_addr, n_addr;
    logic [2:0]                       r_k, n_k;
    logic [1:0]                       r_ax, n_ax;
    logic [1:0]                       r_step, n_step;
    logic [TW-1:0]                    r_tstep, n_tstep;
    logic [TW:0]                      r_sum, n_sum;
    logic signed [PW-1:0]             r_prod, n_prod;
    logic signed [HW-1:0]             r_h  [3];
    logic signed [HW-1:0]             n_h  [3];
    logic signed [HW-1:0]             r_c2 [3];
    logic signed [HW-1:0]             n_c2 [3];
    logic signed [HW-1:0]             r_c1 [3];
    logic signed [HW-1:0]             n_c1 [3];
    logic signed [HW-1:0]             r_c0 [3];
    logic signed [HW-1:0]             n_c0 [3];
    logic                             r_ov, n_ov;
    crpf_pkg::t_out_item              r_out, n_out;
    crpf_pkg::t_point                 r_mem [MAX_WAYPOINTS];
    crpf_pkg::t_point                 r_rd;

    logic                             in_xfer;
    logic                             slot_ok;
    logic [CW-1:0]                    way_cnt;
    logic [CW-1:0]                    i0_inc;
    logic [CW-1:0]                    addr_inc;
    logic signed [HW-1:0]             mul_a;
    logic signed [BW-1:0]             mul_b;
    logic [1:0]                       pt;
    logic signed [HW-1:0]             cnext;
    logic [TW+1:0]                    diff;
    logic [TW:0]                      upd;

    function automatic logic signed [XW-1:0] sat32(input logic signed [HW-1:0] h);
        logic signed [HW-1:0] hf;
        logic                 fits;
        hf   = h >>> 1;
        fits = (&hf[HW-1:XW-1]) | ~(|hf[HW-1:XW-1]);
        if (fits) begin
            sat32 = hf[XW-1:0];
        end else if (hf[HW-1]) begin
            sat32 = {1'b1, {(XW-1){1'b0}}};
        end else begin
            sat32 = {1'b0, {(XW-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [XW-1:0] axis_of(input crpf_pkg::t_point p,
                                                     input logic [1:0] ax);
        case (ax)
            2'd0:    axis_of = p.x;
            2'd1:    axis_of = p.y;
            default: axis_of = p.z;
        endcase
    endfunction

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign in_xfer     = i_in_valid & o_in_ready;
    assign slot_ok     = ({28'd0, i_in_data.waypoint_index} < 32'(MAX_WAYPOINTS));

    always_comb begin
        if (r_cfg_count == '0) begin
            way_cnt = CW'(1);
        end else if ({27'd0, r_cfg_count} > 32'(MAX_WAYPOINTS)) begin
            way_cnt = CW'(MAX_WAYPOINTS);
        end else begin
            way_cnt = r_cfg_count;
        end
    end

    assign i0_inc   = (r_i0 + CW'(1) == way_cnt) ? '0 : r_i0 + CW'(1);
    assign addr_inc = (r_addr + CW'(1) == way_cnt) ? '0 : r_addr + CW'(1);
    assign pt       = 2'(r_k - 3'd1);
    assign diff     = {1'b0, r_sum} - {2'b00, r_cfg_dur};

    always_comb begin
        if (r_state == ST_PMUL) begin
            mul_a = $signed(HW'(r_seg_time));
            mul_b = $signed({1'b0, r_cfg_inv});
        end else begin
            mul_a = r_h[r_ax];
            mul_b = $signed({(BW-FW)'(0), r_seg_param});
        end
    end

    always_comb begin
        case (r_step)
            2'd0:    cnext = r_c2[r_ax];
            2'd1:    cnext = r_c1[r_ax];
            default: cnext = r_c0[r_ax];
        endcase
    end

    always_comb begin
        logic signed [HW-1:0] v;
        logic signed [HW-1:0] v3;
        logic signed [HW-1:0] v5;
        v           = '0;
        v3          = '0;
        v5          = '0;
        n_state     = r_state;
        n_seg_idx   = r_seg_idx;
        n_seg_time  = r_seg_time;
        n_seg_param = r_seg_param;
        n_i0        = r_i0;
        n_addr      = r_addr;
        n_k         = r_k;
        n_ax        = r_ax;
        n_step      = r_step;
        n_tstep     = r_tstep;
        n_sum       = r_sum;
        n_prod      = r_prod;
        n_ov        = r_ov;
        n_out       = r_out;
        upd         = '0;
        for (int a = 0; a < 3; a++) begin
            n_h[a]  = r_h[a];
            n_c2[a] = r_c2[a];
            n_c1[a] = r_c1[a];
            n_c0[a] = r_c0[a];
        end
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_in_data.op == crpf_pkg::OP_TICK && r_cfg_en) begin
                    n_tstep = i_in_data.time_step;
                    n_i0    = CW'(r_seg_idx);
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (r_i0 >= way_cnt) begin
                    n_i0 = r_i0 - way_cnt;
                end else begin
                    n_addr  = (r_i0 == '0) ? way_cnt - CW'(1) : r_i0 - CW'(1);
                    n_k     = '0;
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (r_k != 3'd0) begin
                    for (int a = 0; a < 3; a++) begin
                        v  = HW'(axis_of(r_rd, 2'(a)));
                        v3 = v + (v <<< 1);
                        v5 = v + (v <<< 2);
                        case (pt)
                            2'd0: begin
                                n_h[a]  = -v;
                                n_c2[a] = v <<< 1;
                                n_c1[a] = -v;
                                n_c0[a] = '0;
                            end
                            2'd1: begin
                                n_h[a]  = r_h[a] + v3;
                                n_c2[a] = r_c2[a] - v5;
                                n_c0[a] = v <<< 1;
                            end
                            2'd2: begin
                                n_h[a]  = r_h[a] - v3;
                                n_c2[a] = r_c2[a] + (v <<< 2);
                                n_c1[a] = r_c1[a] + v;
                            end
                            default: begin
                                n_h[a]  = r_h[a] + v;
                                n_c2[a] = r_c2[a] - v;
                            end
                        endcase
                    end
                end
                n_addr = addr_inc;
                if (r_k == 3'd4) begin
                    n_ax    = '0;
                    n_step  = '0;
                    n_state = ST_MUL;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_MUL: begin
                n_prod  = mul_a * mul_b;
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_h[r_ax] = cnext + HW'(r_prod >>> FW);
                n_state   = ST_MUL;
                if (r_ax == 2'd2) begin
                    n_ax = '0;
                    if (r_step == 2'd2) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_step = r_step + 2'd1;
                    end
                end else begin
                    n_ax = r_ax + 2'd1;
                end
            end
            ST_EMIT: begin
                if (!r_ov || i_out_ready) begin
                    n_out.pos_x   = sat32(r_h[0]);
                    n_out.pos_y   = sat32(r_h[1]);
                    n_out.pos_z   = sat32(r_h[2]);
                    n_out.segment = r_i0[crpf_pkg::SEG_W-1:0];
                    n_ov          = 1'b1;
                    n_state       = ST_TSUM;
                end
            end
            ST_TSUM: begin
                n_sum   = {1'b0, r_seg_time} + {1'b0, r_tstep};
                n_state = ST_TUPD;
            end
            ST_TUPD: begin
                if (!diff[TW+1]) begin
                    upd       = diff[TW:0];
                    n_seg_idx = i0_inc[crpf_pkg::SEG_W-1:0];
                end else begin
                    upd = r_sum;
                end
                n_seg_time = upd[TW] ? {TW{1'b1}} : upd[TW-1:0];
                n_state    = ST_PMUL;
            end
            ST_PMUL: begin
                n_prod  = mul_a * mul_b;
                n_state = ST_PSET;
            end
            ST_PSET: begin
                n_seg_param = (|r_prod[PW-1:2*FW]) ? {FW{1'b1}} : r_prod[2*FW-1:FW];
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_count <= crpf_pkg::RST_COUNT;
            r_cfg_dur   <= crpf_pkg::RST_DURATION;
            r_cfg_inv   <= crpf_pkg::RST_INVERSE;
            r_cfg_en    <= 1'b1;
            r_seg_idx   <= '0;
            r_seg_time  <= '0;
            r_seg_param <= '0;
            r_i0        <= '0;
            r_addr      <= '0;
            r_k         <= '0;
            r_ax        <= '0;
            r_step      <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seg_idx   <= n_seg_idx;
            r_seg_time  <= n_seg_time;
            r_seg_param <= n_seg_param;
            r_i0        <= n_i0;
            r_addr      <= n_addr;
            r_k         <= n_k;
            r_ax        <= n_ax;
            r_step      <= n_step;
            r_ov        <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    crpf_pkg::CFG_WAYPOINT_COUNT:   r_cfg_count <= i_cfg_data[CW-1:0];
                    crpf_pkg::CFG_SEGMENT_DURATION: r_cfg_dur   <= i_cfg_data[TW-1:0];
                    crpf_pkg::CFG_DURATION_INVERSE: r_cfg_inv   <= i_cfg_data[TW-1:0];
                    crpf_pkg::CFG_ANIMATE_ENABLE:   r_cfg_en    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tstep <= n_tstep;
        r_sum   <= n_sum;
        r_prod  <= n_prod;
        r_out   <= n_out;
        for (int a = 0; a < 3; a++) begin
            r_h[a]  <= n_h[a];
            r_c2[a] <= n_c2[a];
            r_c1[a] <= n_c1[a];
            r_c0[a] <= n_c0[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in_data.op == crpf_pkg::OP_LOAD && slot_ok) begin
            r_mem[AW'(i_in_data.waypoint_index)] <= '{
                x: i_in_data.coord_x,
                y: i_in_data.coord_y,
                z: i_in_data.coord_z
            };
        end
        r_rd <= r_mem[AW'(r_addr)];
    end

endmodule

/* tb/sv/crpf_position_check.sv */
module crpf_position_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  crpf_pkg::t_in_item                  i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  crpf_pkg::t_out_item                 i_out_data,
    input  logic                                i_cfg_we,
    input  logic [crpf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [crpf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_mismatch_count,
    output int                                  o_positions_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PATH_SLOTS  = 16;
    localparam int     MAX_PRINTED = 200;
    localparam int     CW          = crpf_pkg::COUNT_W;
    localparam int     TW          = crpf_pkg::TIME_W;
    localparam int     XW          = crpf_pkg::COORD_W;
    localparam int     SW          = crpf_pkg::SEG_W;
    localparam int     QW          = crpf_pkg::PARAM_W;
    localparam longint POS_MAX     = 64'sd2147483647;
    localparam longint POS_MIN     = -64'sd2147483648;

    logic [CW-1:0]             cfg_count;
    logic [TW-1:0]             cfg_duration;
    logic [TW-1:0]             cfg_inverse;
    logic                      cfg_enable;
    logic signed [XW-1:0]      way_x [PATH_SLOTS];
    logic signed [XW-1:0]      way_y [PATH_SLOTS];
    logic signed [XW-1:0]      way_z [PATH_SLOTS];
    logic [SW-1:0]             seg_index;
    logic [TW-1:0]             seg_time;
    logic [QW-1:0]             seg_param;
    crpf_pkg::t_out_item       owed_positions [$];

    initial o_mismatch_count = 0;
    initial o_positions_owed = 0;

    function automatic logic signed [XW-1:0] spline_axis(input logic signed [XW-1:0] p0,
            input logic signed [XW-1:0] p1, input logic signed [XW-1:0] p2,
            input logic signed [XW-1:0] p3, input logic [QW-1:0] param);
        longint a;
        longint b;
        longint c;
        longint d;
        longint c3;
        longint c2;
        longint c1;
        longint c0;
        longint tt;
        longint h;
        a  = longint'(p0);
        b  = longint'(p1);
        c  = longint'(p2);
        d  = longint'(p3);
        c3 = -a + 3 * b - 3 * c + d;
        c2 = 2 * a - 5 * b + 4 * c - d;
        c1 = c - a;
        c0 = 2 * b;
        tt = longint'(param);
        h  = c3;
        h  = c2 + ((h * tt) >>> 16);
        h  = c1 + ((h * tt) >>> 16);
        h  = c0 + ((h * tt) >>> 16);
        h  = h >>> 1;
        if (h > POS_MAX) h = POS_MAX;
        if (h < POS_MIN) h = POS_MIN;
        return h[XW-1:0];
    endfunction

    task automatic report(input string msg);
        if (o_mismatch_count < MAX_PRINTED) $display("mismatch: %s", msg);
        o_mismatch_count++;
    endtask

    always @(posedge i_clk) begin : track
        int                  n;
        int                  i0;
        int                  i1;
        int                  i2;
        int                  ip;
        logic [SW-1:0]       s0;
        logic [SW-1:0]       s1;
        logic [SW-1:0]       s2;
        logic [SW-1:0]       sp;
        longint              sum;
        longint              prod;
        crpf_pkg::t_out_item want;
        if (!i_rst_n) begin
            cfg_count    = crpf_pkg::RST_COUNT;
            cfg_duration = crpf_pkg::RST_DURATION;
            cfg_inverse  = crpf_pkg::RST_INVERSE;
            cfg_enable   = 1'b1;
            seg_index    = '0;
            seg_time     = '0;
            seg_param    = '0;
            owed_positions.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    crpf_pkg::CFG_WAYPOINT_COUNT:   cfg_count    = i_cfg_data[CW-1:0];
                    crpf_pkg::CFG_SEGMENT_DURATION: cfg_duration = i_cfg_data[TW-1:0];
                    crpf_pkg::CFG_DURATION_INVERSE: cfg_inverse  = i_cfg_data[TW-1:0];
                    crpf_pkg::CFG_ANIMATE_ENABLE:   cfg_enable   = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                if (i_in_data.op == crpf_pkg::OP_LOAD) begin
                    way_x[i_in_data.waypoint_index] = i_in_data.coord_x;
                    way_y[i_in_data.waypoint_index] = i_in_data.coord_y;
                    way_z[i_in_data.waypoint_index] = i_in_data.coord_z;
                end else if (cfg_enable) begin
                    n = int'(cfg_count);
                    if (n == 0) n = 1;
                    if (n > PATH_SLOTS) n = PATH_SLOTS;
                    i0 = int'(seg_index) % n;
                    i1 = (i0 + 1) % n;
                    i2 = (i1 + 1) % n;
                    ip = (i0 + n - 1) % n;
                    s0 = i0[SW-1:0];
                    s1 = i1[SW-1:0];
                    s2 = i2[SW-1:0];
                    sp = ip[SW-1:0];
                    want.pos_x   = spline_axis(way_x[sp], way_x[s0], way_x[s1], way_x[s2],
                                               seg_param);
                    want.pos_y   = spline_axis(way_y[sp], way_y[s0], way_y[s1], way_y[s2],
                                               seg_param);
                    want.pos_z   = spline_axis(way_z[sp], way_z[s0], way_z[s1], way_z[s2],
                                               seg_param);
                    want.segment = s0;
                    owed_positions.push_back(want);

                    sum = longint'(seg_time) + longint'(i_in_data.time_step);
                    if (sum >= longint'(cfg_duration)) begin
                        sum       = sum - longint'(cfg_duration);
                        seg_index = s1;
                    end
                    if (sum > 64'sh00FF_FFFF) sum = 64'sh00FF_FFFF;
                    seg_time = sum[TW-1:0];
                    prod = (longint'(seg_time) * longint'(cfg_inverse)) >>> 16;
                    if (prod > 64'sh0000_FFFF) prod = 64'sh0000_FFFF;
                    seg_param = prod[QW-1:0];
                end
            end

            if (i_out_valid && i_out_ready) begin
                if (owed_positions.size() == 0) begin
                    report($sformatf("position with none owed, segment %0d",
                                     i_out_data.segment));
                end else begin
                    want = owed_positions.pop_front();
                    if (i_out_data.pos_x !== want.pos_x)
                        report($sformatf("pos_x got %0d expected %0d",
                                         $signed(i_out_data.pos_x), $signed(want.pos_x)));
                    if (i_out_data.pos_y !== want.pos_y)
                        report($sformatf("pos_y got %0d expected %0d",
                                         $signed(i_out_data.pos_y), $signed(want.pos_y)));
                    if (i_out_data.pos_z !== want.pos_z)
                        report($sformatf("pos_z got %0d expected %0d",
                                         $signed(i_out_data.pos_z), $signed(want.pos_z)));
                    if (i_out_data.segment !== want.segment)
                        report($sformatf("segment got %0d expected %0d",
                                         i_out_data.segment, want.segment));
                end
            end
        end
        o_positions_owed = owed_positions.size();
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TW             = crpf_pkg::TIME_W;
    localparam int SW             = crpf_pkg::SEG_W;
    localparam int XW             = crpf_pkg::COORD_W;
    localparam int CW             = crpf_pkg::COUNT_W;
    localparam int IW             = crpf_pkg::CFG_IDX_W;
    localparam int DW             = crpf_pkg::CFG_DATA_W;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    crpf_pkg::t_in_item    in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    crpf_pkg::t_out_item   out_data;
    logic                  cfg_we    = 1'b0;
    logic [IW-1:0]         cfg_index = '0;
    logic [DW-1:0]         cfg_data  = '0;

    int                    mismatch_count;
    int                    positions_owed;
    int                    send_idle_pct   = 0;
    int                    recv_stall_pct  = 0;
    int                    quiet_cycles    = 0;
    logic [TW-1:0]         active_duration = crpf_pkg::RST_DURATION;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    catmull_rom_path_follower_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    crpf_position_check position_monitor (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_data       (out_data),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_positions_owed (positions_owed)
    );

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [XW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(0, 32'h0010_0000)) - 32'd524288;
        endcase
    endfunction

    function automatic crpf_pkg::t_in_item make_item(input logic op,
            input logic [SW-1:0] slot,
            input logic signed [XW-1:0] x, input logic signed [XW-1:0] y,
            input logic signed [XW-1:0] z, input logic [TW-1:0] step);
        crpf_pkg::t_in_item item;
        item.op             = op;
        item.waypoint_index = slot;
        item.coord_x        = x;
        item.coord_y        = y;
        item.coord_z        = z;
        item.time_step      = step;
        return item;
    endfunction

    function automatic crpf_pkg::t_in_item random_item();
        logic [TW-1:0] step;
        case ($urandom_range(0, 5))
            0:       step = '0;
            1:       step = TW'($urandom);
            2:       step = 24'hFF_FFFF;
            3:       step = active_duration;
            default: step = TW'($urandom_range(0, active_duration / 2 + 1));
        endcase
        return make_item(($urandom_range(0, 4) == 0) ? crpf_pkg::OP_LOAD : crpf_pkg::OP_TICK,
                         SW'($urandom_range(0, 15)), rand_coord(), rand_coord(),
                         rand_coord(), step);
    endfunction

    task automatic send_item(input crpf_pkg::t_in_item item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (positions_owed != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [CW-1:0] count, input logic [TW-1:0] dur,
            input logic [TW-1:0] inv, input logic enable, input int sender_idle,
            input int receiver_stall, input int items);
        settle();
        write_reg(crpf_pkg::CFG_WAYPOINT_COUNT, DW'(count));
        write_reg(crpf_pkg::CFG_SEGMENT_DURATION, dur);
        write_reg(crpf_pkg::CFG_DURATION_INVERSE, inv);
        write_reg(crpf_pkg::CFG_ANIMATE_ENABLE, DW'(enable));
        cfg_we          <= 1'b0;
        active_duration  = dur;
        send_idle_pct    = sender_idle;
        recv_stall_pct   = receiver_stall;
        repeat (items) send_item(random_item());
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(make_item(crpf_pkg::OP_LOAD, 4'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0,
                            '0));
        send_item(make_item(crpf_pkg::OP_LOAD, 4'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1,
                            24'hFF_FFFF));
        send_item(make_item(crpf_pkg::OP_LOAD, 4'd2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh8000_0000, TW'($urandom)));
        send_item(make_item(crpf_pkg::OP_LOAD, 4'd3, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh7FFF_FFFF, TW'($urandom)));
        for (int k = 4; k < 16; k++) begin
            send_item(make_item(crpf_pkg::OP_LOAD, k[SW-1:0], rand_coord(), rand_coord(),
                                rand_coord(), TW'($urandom)));
        end

        send_item(make_item(crpf_pkg::OP_TICK, 4'd15, 32'sd0, 32'sd0, 32'sd0, 24'd0));
        send_item(make_item(crpf_pkg::OP_TICK, 4'd0, -32'sd1, -32'sd1, -32'sd1, 24'd16384));
        send_item(make_item(crpf_pkg::OP_TICK, 4'd5, rand_coord(), rand_coord(), rand_coord(),
                            24'd32768));
        send_item(make_item(crpf_pkg::OP_TICK, 4'd9, rand_coord(), rand_coord(), rand_coord(),
                            24'hFF_FFFF));
        send_item(make_item(crpf_pkg::OP_TICK, 4'd3, rand_coord(), rand_coord(), rand_coord(),
                            24'hFF_FFFF));
        send_item(make_item(crpf_pkg::OP_TICK, 4'd7, rand_coord(), rand_coord(), rand_coord(),
                            24'd0));
        send_item(make_item(crpf_pkg::OP_TICK, 4'd1, rand_coord(), rand_coord(), rand_coord(),
                            crpf_pkg::RST_DURATION));
        send_item(make_item(crpf_pkg::OP_TICK, 4'd12, rand_coord(), rand_coord(), rand_coord(),
                            24'd1));

        run_phase(5'd4,  24'd65536,    24'd65536,    1'b1, 0,  0,  250);
        run_phase(5'd16, 24'hFF_FFFF,  24'd1,        1'b1, 52, 0,  200);
        run_phase(5'd3,  24'd1,        24'hFF_FFFF,  1'b1, 0,  52, 200);
        run_phase(5'd0,  24'd0,        24'd0,        1'b1, 15, 15, 100);
        run_phase(5'd31, 24'd32768,    24'd131072,   1'b1, 0,  0,  250);
        run_phase(5'd16, 24'h00_3000,  24'h05_5555,  1'b0, 52, 0,  100);
        run_phase(5'd1,  24'd40000,    24'd107374,   1'b1, 0,  52, 200);
        run_phase(5'd7,  24'd100000,   24'd42950,    1'b1, 15, 15, 250);
        run_phase(5'd5,  24'd65536,    24'd65536,    1'b1, 0,  0,  280);

        settle();
        if (mismatch_count == 0 && positions_owed == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
